// File: hw/rtl/cpts_pkg.sv
// Package for the counter/priority task scheduler.
// Sizes, request codes, transfer payload types and the cell interface types.
// No dependencies.
package cpts_pkg;

    localparam int unsigned NUM_SLOTS    = 64;
    localparam int unsigned COUNTER_BITS = 8;

    localparam int unsigned SLOT_W = $clog2(NUM_SLOTS);
    localparam int unsigned CNT_W  = COUNTER_BITS;
    localparam int unsigned PRIO_W = 7;
    localparam int unsigned SUM_W  = ((CNT_W > PRIO_W) ? CNT_W : PRIO_W) + 1;

    localparam logic [CNT_W-1:0] CNT_MAX  = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_HOME = CNT_W'(15);
    localparam logic [PRIO_W-1:0] PRIO_HOME = PRIO_W'(15);

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_RUN   = 2'd1;
    localparam logic [1:0] REQ_CNT   = 2'd2;
    localparam logic [1:0] REQ_SCHED = 2'd3;

    typedef struct packed {
        logic [1:0] req_type;
        logic [5:0] slot;
        logic       occupy;
        logic       runnable;
        logic [7:0] counter_value;
        logic [6:0] priority_value;
    } cpts_in_t;

    typedef struct packed {
        logic [5:0] next_slot;
        logic       switched;
        logic       recomputed;
        logic       none_runnable;
        logic       stuck_zero;
    } cpts_out_t;

    typedef struct packed {
        logic              en;
        logic [1:0]        req_type;
        logic              occupy;
        logic              runnable;
        logic [CNT_W-1:0]  cnt;
        logic [PRIO_W-1:0] prio;
    } cpts_wr_t;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] idx;
        logic [CNT_W-1:0]  cnt;
    } cpts_tok_t;

endpackage

// File: hw/rtl/cpts_cell.sv
// One task slot of the scheduler chain: slot state plus one stage of the scan.
// Depends on cpts_pkg.
module cpts_cell
    import cpts_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [SLOT_W-1:0] idx_i,
    input  cpts_wr_t          wr_i,
    input  logic              sel_i,
    input  logic              rec_i,
    input  logic              tok_valid_i,
    input  cpts_tok_t         tok_i,
    output logic              tok_valid_o,
    output cpts_tok_t         tok_o
);

    logic              valid_reg, valid_next;
    logic              run_reg, run_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [PRIO_W-1:0] prio_reg, prio_next;
    logic              tok_valid_reg;
    cpts_tok_t         tok_reg, tok_next;

    logic              home;
    logic [SUM_W-1:0]  sum;
    logic              take;

    assign home = (idx_i == '0);
    assign sum  = SUM_W'(cnt_reg >> 1) + SUM_W'(prio_reg);

    always_comb begin
        valid_next = valid_reg;
        run_next   = run_reg;
        cnt_next   = cnt_reg;
        prio_next  = prio_reg;
        if (wr_i.en && sel_i) begin
            case (wr_i.req_type)
                REQ_LOAD: begin
                    valid_next = wr_i.occupy;
                    run_next   = wr_i.occupy & wr_i.runnable;
                    cnt_next   = wr_i.occupy ? wr_i.cnt : '0;
                    prio_next  = wr_i.occupy ? wr_i.prio : '0;
                end
                REQ_RUN: run_next = wr_i.runnable;
                REQ_CNT: cnt_next = wr_i.cnt;
                default: ;
            endcase
        end else if (rec_i && valid_reg) begin
            cnt_next = (sum > SUM_W'(CNT_MAX)) ? CNT_MAX : CNT_W'(sum);
        end
    end

    // strict compare: scan runs from high index down, so ties keep the higher slot
    assign take = valid_reg && run_reg && (!tok_i.found || (cnt_reg > tok_i.cnt));

    always_comb begin
        tok_next = tok_i;
        if (take) begin
            tok_next.found = 1'b1;
            tok_next.idx   = idx_i;
            tok_next.cnt   = cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= home;
            run_reg       <= home;
            cnt_reg       <= home ? CNT_HOME : '0;
            prio_reg      <= home ? PRIO_HOME : '0;
            tok_valid_reg <= 1'b0;
        end else begin
            valid_reg     <= valid_next;
            run_reg       <= run_next;
            cnt_reg       <= cnt_next;
            prio_reg      <= prio_next;
            tok_valid_reg <= tok_valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        tok_reg <= tok_next;
    end

    assign tok_valid_o = tok_valid_reg;
    assign tok_o       = tok_reg;

endmodule

// File: hw/rtl/counter_priority_task_scheduler_unit.sv
// Top level of the counter/priority task scheduler: request sequencer and chain of slot cells.
// Depends on cpts_pkg and cpts_cell.
//
// Load, free, set-runnable and set-counter requests take effect in the cycle of the
// input transfer and their result is registered. A schedule request sends a scan
// token down the row of NUM_SLOTS cells, one cell per cycle; when the best counter
// is zero, all counters are recomputed (all cells at once) and the second scan
// starts in the cycle after the recompute. One request is in work at a time; a new one
// is taken only once the previous result has left m_ or leaves in the same cycle.
module counter_priority_task_scheduler_unit
    import cpts_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  cpts_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output cpts_out_t m_data
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN1  = 3'd1;
    localparam logic [2:0] ST_REC    = 3'd2;
    localparam logic [2:0] ST_SCAN2  = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;
    localparam logic [2:0] ST_LAUNCH = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [SLOT_W-1:0] cur_reg, cur_next;
    logic [SLOT_W-1:0] best_reg, best_next;
    logic              rec_reg, rec_next;
    logic              none_reg, none_next;
    logic              stuck_reg, stuck_next;
    logic              m_valid_reg, m_valid_next;
    cpts_out_t         m_data_reg, m_data_next;

    logic              accept;
    logic              out_free;
    logic              start;
    logic              rec_pulse;
    cpts_wr_t          wr;

    logic              tok_valid [NUM_SLOTS+1];
    cpts_tok_t         tok       [NUM_SLOTS+1];

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) && out_free;
    assign accept    = s_valid && s_ready;
    assign rec_pulse = (state_reg == ST_REC);
    // a scan starts on an accepted schedule request; the second scan once the recomputed counters are in the cells
    assign start     = (accept && (s_data.req_type == REQ_SCHED)) || (state_reg == ST_LAUNCH);

    assign wr.en       = accept && (s_data.req_type != REQ_SCHED);
    assign wr.req_type = s_data.req_type;
    assign wr.occupy   = s_data.occupy;
    assign wr.runnable = s_data.runnable;
    assign wr.cnt      = CNT_W'(s_data.counter_value);
    assign wr.prio     = s_data.priority_value;

    assign tok_valid[NUM_SLOTS] = start;
    assign tok[NUM_SLOTS]       = '0;

    for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
        cpts_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .idx_i       (SLOT_W'(k)),
            .wr_i        (wr),
            .sel_i       (32'(s_data.slot) == k),
            .rec_i       (rec_pulse),
            .tok_valid_i (tok_valid[k+1]),
            .tok_i       (tok[k+1]),
            .tok_valid_o (tok_valid[k]),
            .tok_o       (tok[k])
        );
    end

    always_comb begin
        state_next   = state_reg;
        cur_next     = cur_reg;
        best_next    = best_reg;
        rec_next     = rec_reg;
        none_next    = none_reg;
        stuck_next   = stuck_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_data.req_type == REQ_SCHED) begin
                        rec_next   = 1'b0;
                        none_next  = 1'b0;
                        stuck_next = 1'b0;
                        state_next = ST_SCAN1;
                    end else begin
                        m_valid_next = 1'b1;
                        m_data_next  = '0;
                        m_data_next.next_slot = 6'(cur_reg);
                    end
                end
            end
            ST_SCAN1: begin
                if (tok_valid[0]) begin
                    if (!tok[0].found) begin
                        best_next  = '0;
                        none_next  = 1'b1;
                        state_next = ST_DONE;
                    end else if (tok[0].cnt == '0) begin
                        state_next = ST_REC;
                    end else begin
                        best_next  = tok[0].idx;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_REC: begin
                rec_next   = 1'b1;
                state_next = ST_LAUNCH;
            end
            ST_LAUNCH: begin
                state_next = ST_SCAN2;
            end
            ST_SCAN2: begin
                if (tok_valid[0]) begin
                    best_next  = tok[0].found ? tok[0].idx : '0;
                    stuck_next = (tok[0].cnt == '0);
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cur_next     = best_reg;
                    m_valid_next = 1'b1;
                    m_data_next.next_slot     = 6'(best_reg);
                    m_data_next.switched      = (best_reg != cur_reg);
                    m_data_next.recomputed    = rec_reg;
                    m_data_next.none_runnable = none_reg;
                    m_data_next.stuck_zero    = stuck_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cur_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cur_reg     <= cur_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        best_reg   <= best_next;
        rec_reg    <= rec_next;
        none_reg   <= none_next;
        stuck_reg  <= stuck_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_tok_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        tok_valid[0] |-> (state_reg == ST_SCAN1 || state_reg == ST_SCAN2))
        else $error("scan token left the chain outside a scan");

    a_rec_then_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_REC) |=> (state_reg == ST_LAUNCH && start))
        else $error("recompute not followed by a second scan");

    a_none_slot0: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.none_runnable) |-> (m_data.next_slot == '0 && !m_data.recomputed))
        else $error("no-runnable result does not pick slot 0");

    a_stuck_rec: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.stuck_zero) |-> m_data.recomputed)
        else $error("stuck_zero without recompute");

endmodule

// File: tb/tb_counter_priority_task_scheduler_unit.sv
// Self-checking testbench for counter_priority_task_scheduler_unit.
// Holds its own model of the slot table and checks every result transfer.
// Depends on cpts_pkg and the scheduler RTL.
`timescale 1ns / 100ps

module tb_counter_priority_task_scheduler_unit;
    import cpts_pkg::*;

    localparam int QUIET_LIMIT = 1000;

    class sched_scoreboard;
        bit                valid_tab [NUM_SLOTS];
        bit                run_tab   [NUM_SLOTS];
        logic [CNT_W-1:0]  cnt_tab   [NUM_SLOTS];
        logic [PRIO_W-1:0] prio_tab  [NUM_SLOTS];
        logic [SLOT_W-1:0] cur_slot;
        cpts_out_t         due_results [$];
        int mismatches, requests, scheds, refills, stuck_cnt, idle_picks, switches;

        function new();
            for (int k = 0; k < NUM_SLOTS; k++) begin
                valid_tab[k] = 1'b0;
                run_tab[k]   = 1'b0;
                cnt_tab[k]   = '0;
                prio_tab[k]  = '0;
            end
            valid_tab[0] = 1'b1;
            run_tab[0]   = 1'b1;
            cnt_tab[0]   = CNT_HOME;
            prio_tab[0]  = PRIO_HOME;
            cur_slot     = '0;
        endfunction

        // Highest counter among valid runnable slots; higher index wins ties.
        function int pick(output logic [CNT_W-1:0] top);
            int best;
            best = -1;
            top  = '0;
            for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
                if (valid_tab[k] && run_tab[k] && (best < 0 || cnt_tab[k] > top)) begin
                    best = k;
                    top  = cnt_tab[k];
                end
            end
            return best;
        endfunction

        function void note_request(cpts_in_t req);
            cpts_out_t         want;
            logic [CNT_W-1:0]  top;
            logic [SLOT_W-1:0] prev;
            int                best;
            int unsigned       sum;
            want = '0;
            requests++;
            if (req.req_type == REQ_SCHED) begin
                scheds++;
                prev = cur_slot;
                best = pick(top);
                if (best < 0) begin
                    want.none_runnable = 1'b1;
                    best = 0;
                end else if (top == '0) begin
                    for (int k = 0; k < NUM_SLOTS; k++) begin
                        if (valid_tab[k]) begin
                            sum = (cnt_tab[k] >> 1) + prio_tab[k];
                            cnt_tab[k] = (sum > CNT_MAX) ? CNT_MAX : CNT_W'(sum);
                        end
                    end
                    want.recomputed = 1'b1;
                    best = pick(top);
                    if (best < 0)
                        best = 0;
                    if (top == '0)
                        want.stuck_zero = 1'b1;
                end
                cur_slot = SLOT_W'(best);
                want.switched = (cur_slot != prev);
                refills    += want.recomputed;
                stuck_cnt  += want.stuck_zero;
                idle_picks += want.none_runnable;
                switches   += want.switched;
            end else if (req.slot < NUM_SLOTS) begin
                case (req.req_type)
                    REQ_LOAD: begin
                        valid_tab[req.slot] = req.occupy;
                        run_tab[req.slot]   = req.occupy & req.runnable;
                        cnt_tab[req.slot]   = req.occupy ? CNT_W'(req.counter_value) : '0;
                        prio_tab[req.slot]  = req.occupy ? req.priority_value : '0;
                    end
                    REQ_RUN: run_tab[req.slot] = req.runnable;
                    default: cnt_tab[req.slot] = CNT_W'(req.counter_value);
                endcase
            end
            want.next_slot = cur_slot;
            due_results.push_back(want);
        endfunction

        function void report(string what, cpts_out_t want, cpts_out_t got);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t %s: want slot %0d sw %b rc %b none %b stuck %b, got slot %0d sw %b rc %b none %b stuck %b",
                         $time, what, want.next_slot, want.switched, want.recomputed,
                         want.none_runnable, want.stuck_zero, got.next_slot, got.switched,
                         got.recomputed, got.none_runnable, got.stuck_zero);
        endfunction

        function void check_result(cpts_out_t got);
            cpts_out_t want;
            if (due_results.size() == 0) begin
                report("unexpected transfer", '0, got);
                return;
            end
            want = due_results.pop_front();
            if (got.next_slot !== want.next_slot || got.switched !== want.switched ||
                got.recomputed !== want.recomputed || got.none_runnable !== want.none_runnable ||
                got.stuck_zero !== want.stuck_zero)
                report("result mismatch", want, got);
        endfunction
    endclass

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    cpts_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    cpts_out_t m_data;

    bit              idling = 1'b1;
    int              quiet  = 0;
    sched_scoreboard sb;

    counter_priority_task_scheduler_unit uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= !idling || ($urandom_range(99) >= 20);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_result(m_data);
            if (s_valid && s_ready)
                sb.note_request(s_data);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    function automatic cpts_in_t make_req(logic [1:0] kind, int unsigned slot, bit occ, bit run,
                                          int unsigned cnt, int unsigned prio);
        cpts_in_t req;
        req.req_type       = kind;
        req.slot           = slot[5:0];
        req.occupy         = occ;
        req.runnable       = run;
        req.counter_value  = cnt[7:0];
        req.priority_value = prio[6:0];
        return req;
    endfunction

    // Mostly a few hot slots with small counters so refills and ties show up often.
    function automatic cpts_in_t rand_req();
        int unsigned r, slot, cnt, prio;
        logic [1:0]  kind;
        r = $urandom_range(99);
        kind = (r < 25) ? REQ_LOAD : (r < 45) ? REQ_RUN : (r < 65) ? REQ_CNT : REQ_SCHED;
        if ($urandom_range(99) < 60) begin
            slot = $urandom_range(15);
            slot = (slot < 8) ? slot : slot + 48;
        end else begin
            slot = $urandom_range(63);
        end
        r = $urandom_range(99);
        cnt = (r < 40) ? 0 : (r < 70) ? $urandom_range(7) : $urandom_range(255);
        r = $urandom_range(99);
        prio = (r < 30) ? 0 : (r < 70) ? $urandom_range(15) : $urandom_range(127);
        return make_req(kind, slot, $urandom_range(99) < 80, $urandom_range(99) < 70, cnt, prio);
    endfunction

    task automatic send(input cpts_in_t req);
        int gap;
        gap = (idling && $urandom_range(99) < 20) ? $urandom_range(4, 1) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
    endtask

    initial begin
        sb = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send(make_req(REQ_SCHED, 0, 0, 0, 0, 0));
        send(make_req(REQ_LOAD, 63, 1, 1, 255, 127));
        send(make_req(REQ_SCHED, 0, 0, 0, 0, 0));
        send(make_req(REQ_LOAD, 1, 1, 1, 255, 0));
        send(make_req(REQ_SCHED, 63, 1, 1, 255, 127));  // tie, higher index stays
        send(make_req(REQ_CNT, 63, 0, 0, 0, 0));
        send(make_req(REQ_CNT, 1, 0, 0, 0, 0));
        send(make_req(REQ_CNT, 0, 0, 0, 0, 0));
        send(make_req(REQ_SCHED, 0, 0, 0, 0, 0));       // all zero: refill
        send(make_req(REQ_LOAD, 63, 0, 1, 255, 127));   // free the current slot
        send(make_req(REQ_SCHED, 0, 0, 0, 0, 0));
        send(make_req(REQ_RUN, 40, 0, 1, 0, 0));        // empty slot flags
        send(make_req(REQ_CNT, 40, 0, 0, 200, 0));
        send(make_req(REQ_SCHED, 0, 0, 0, 0, 0));
        send(make_req(REQ_LOAD, 0, 0, 0, 0, 0));        // free slot 0
        send(make_req(REQ_SCHED, 0, 0, 0, 0, 0));       // zero after refill
        send(make_req(REQ_RUN, 1, 0, 0, 0, 0));
        send(make_req(REQ_SCHED, 0, 0, 0, 0, 0));       // nothing runnable
        send(make_req(REQ_LOAD, 0, 1, 1, 15, 15));
        send(make_req(REQ_LOAD, 62, 1, 0, 255, 127));
        send(make_req(REQ_SCHED, 0, 0, 0, 0, 0));

        for (int i = 0; i < 630; i++) begin
            idling = !(i >= 250 && i < 400);
            send(rand_req());
        end
        s_valid <= 1'b0;
        idling = 1'b1;

        while (sb.due_results.size() != 0) @(posedge aclk);
        repeat (2 * NUM_SLOTS + 8) @(posedge aclk);

        $display("%0d requests, %0d schedules: %0d switched, %0d refilled counters",
                 sb.requests, sb.scheds, sb.switches, sb.refills);
        $display("%0d schedules stayed at zero after refill, %0d found no runnable task",
                 sb.stuck_cnt, sb.idle_picks);
        if (sb.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatching transfers", sb.mismatches);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
